// ===== src/izhikevich_neuron_step_defines.svh =====
// Assertion macros for the Izhikevich neuron step block.
`ifndef IZHIKEVICH_NEURON_STEP_DEFINES_SVH
`define IZHIKEVICH_NEURON_STEP_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only out of reset.
`define IZH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset as well.
`define IZH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define IZH_ASSERT(lbl, prop, msg)
`define IZH_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== src/izh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Izhikevich neuron step block.
package izh_pkg;

    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_POTENTIAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_JUMP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DT_SHIFT             = 3'd5;

    // Q16.16 constants and the cap on the substep shift
    localparam logic signed [31:0] REST_POT  = -32'sd4259840;   // -65
    localparam logic signed [31:0] FLOOR_POT = -32'sd4915200;   // -75
    localparam logic signed [31:0] PEAK_POT  = 32'sd1966080;    // 30
    localparam logic signed [47:0] BIAS_TERM = 48'sd9175040;    // 140
    localparam logic [11:0]        COEF_SQ   = 12'd2621;        // 0.04 * 2^16
    localparam logic [3:0]         MAX_SHIFT = 4'd8;

    typedef struct packed {
        logic [16:0]        recovery_rate;
        logic [16:0]        recovery_sensitivity;
        logic signed [23:0] reset_potential;
        logic [20:0]        recovery_jump;
        logic [26:0]        current_gain;
        logic [3:0]         dt_shift;
    } t_cfg;

    typedef struct packed {
        logic load;     // capture drive term, clear substep counter
        logic mul1;     // v*v and b*v
        logic mul2;     // 0.04*sq and a*(bv-u)
        logic update;   // Euler update of v and u
        logic commit;   // spike / floor, window count, output register
    } t_cmd;

    typedef struct packed {
        logic last_substep;
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] res;
        if (x > 48'sh0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < -48'sh0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ===== src/izh_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the Izhikevich neuron step block.
module izh_cfg_regs import izh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECOVERY_RATE:        n_cfg.recovery_rate        = i_cfg_data[16:0];
                CFG_RECOVERY_SENSITIVITY: n_cfg.recovery_sensitivity = i_cfg_data[16:0];
                CFG_RESET_POTENTIAL:      n_cfg.reset_potential      = i_cfg_data[23:0];
                CFG_RECOVERY_JUMP:        n_cfg.recovery_jump        = i_cfg_data[20:0];
                CFG_CURRENT_GAIN:         n_cfg.current_gain         = i_cfg_data[26:0];
                CFG_DT_SHIFT:             n_cfg.dt_shift             = i_cfg_data[3:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.recovery_rate        <= 17'd1311;
            r_cfg.recovery_sensitivity <= 17'd13107;
            r_cfg.reset_potential      <= -24'sd4259840;
            r_cfg.recovery_jump        <= 21'd524288;
            r_cfg.current_gain         <= 27'd65536;
            r_cfg.dt_shift             <= 4'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/izh_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the Izhikevich neuron step: handshakes and substep loop.
module izh_ctrl import izh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    // output register is free when empty or its beat leaves this cycle
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.last_substep ? ST_FINISH : ST_MUL1;
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/izh_datapath.sv =====
`timescale 1ns / 1ps
// Izhikevich neuron datapath: state, multipliers, Euler update, spike window.
module izh_datapath import izh_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_input_current,
    output logic               o_fired,
    output logic signed [31:0] o_membrane_potential,
    output logic signed [31:0] o_recovery_value,
    output logic [CNT_W-1:0]   o_window_spikes
);

    // neuron state
    logic signed [31:0] r_v;
    logic signed [31:0] r_u;
    logic [WINDOW-1:0]  r_hist;
    logic [CNT_W-1:0]   r_count;

    // per-item and per-substep working registers
    logic signed [43:0] r_drive;
    logic [7:0]         r_cnt;
    logic [3:0]         r_s;
    logic signed [63:0] r_vv;
    logic signed [49:0] r_bvp;
    logic [58:0]        r_sqc;
    logic signed [52:0] r_dup;

    // result register
    logic               r_fired;
    logic signed [31:0] r_out_v;
    logic signed [31:0] r_out_u;
    logic [CNT_W-1:0]   r_out_cnt;

    logic signed [59:0] w_drive_p;
    logic signed [63:0] w_vv;
    logic signed [49:0] w_bvp;
    logic [46:0]        w_sq;
    logic [58:0]        w_sqc;
    logic signed [33:0] w_bv;
    logic signed [34:0] w_diff;
    logic signed [52:0] w_dup;
    logic signed [47:0] w_dv;
    logic signed [36:0] w_du;
    logic signed [47:0] w_nv_sum;
    logic signed [47:0] w_nu_sum;
    logic signed [31:0] w_nv;
    logic signed [31:0] w_nu;
    logic [3:0]         w_s_clamped;

    logic               w_spike;
    logic signed [31:0] w_fin_v;
    logic signed [31:0] w_fin_u;
    logic               w_leaving;
    logic [WINDOW-1:0]  n_hist;
    logic [CNT_W-1:0]   n_count;

    // drive term, once per item
    assign w_drive_p   = $signed({1'b0, i_cfg.current_gain}) * i_input_current;
    assign w_s_clamped = (i_cfg.dt_shift > MAX_SHIFT) ? MAX_SHIFT : i_cfg.dt_shift;

    // first multiply stage
    assign w_vv  = r_v * r_v;
    assign w_bvp = $signed({1'b0, i_cfg.recovery_sensitivity}) * r_v;

    // second multiply stage; v*v is never negative
    assign w_sq   = r_vv[62:16];
    assign w_sqc  = w_sq * COEF_SQ;
    assign w_bv   = r_bvp[49:16];
    assign w_diff = 35'(w_bv) - 35'(r_u);
    assign w_dup  = $signed({1'b0, i_cfg.recovery_rate}) * w_diff;

    // Euler update; arithmetic shifts give floor rounding
    assign w_dv = 48'($signed({1'b0, r_sqc[58:16]}))
                + (48'(r_v) <<< 2) + 48'(r_v)
                + BIAS_TERM - 48'(r_u) + 48'(r_drive);
    assign w_du     = r_dup[52:16];
    assign w_nv_sum = 48'(r_v) + (w_dv >>> r_s);
    assign w_nu_sum = 48'(r_u) + 48'(w_du >>> r_s);
    assign w_nv     = sat32(w_nv_sum);
    assign w_nu     = sat32(w_nu_sum);

    assign o_stat.last_substep = ({1'b0, r_cnt} == ((9'd1 << r_s) - 9'd1));

    // spike and floor
    always_comb begin
        w_spike = 1'b0;
        w_fin_v = r_v;
        w_fin_u = r_u;
        if (r_v > PEAK_POT) begin
            w_spike = 1'b1;
            w_fin_v = 32'(i_cfg.reset_potential);
            w_fin_u = sat32(48'(r_u) + $signed({27'b0, i_cfg.recovery_jump}));
        end else if (r_v < FLOOR_POT) begin
            w_fin_v = REST_POT;
        end
    end

    assign w_leaving = r_hist[WINDOW-1];
    assign n_hist    = (r_hist << 1) | WINDOW'(w_spike);
    assign n_count   = r_count + CNT_W'(w_spike) - CNT_W'(w_leaving);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= REST_POT;
            r_u     <= '0;
            r_hist  <= '0;
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_v <= w_nv;
            r_u <= w_nu;
        end else if (i_cmd.commit) begin
            r_v     <= w_fin_v;
            r_u     <= w_fin_u;
            r_hist  <= n_hist;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_drive <= w_drive_p[59:16];
            r_s     <= w_s_clamped;
            r_cnt   <= '0;
        end else if (i_cmd.update) begin
            r_cnt <= r_cnt + 8'd1;
        end
        if (i_cmd.mul1) begin
            r_vv  <= w_vv;
            r_bvp <= w_bvp;
        end
        if (i_cmd.mul2) begin
            r_sqc <= w_sqc;
            r_dup <= w_dup;
        end
        if (i_cmd.commit) begin
            r_fired   <= w_spike;
            r_out_v   <= w_fin_v;
            r_out_u   <= w_fin_u;
            r_out_cnt <= n_count;
        end
    end

    assign o_fired              = r_fired;
    assign o_membrane_potential = r_out_v;
    assign o_recovery_value     = r_out_u;
    assign o_window_spikes      = r_out_cnt;

endmodule

// ===== src/izhikevich_neuron_step.sv =====
`timescale 1ns / 1ps
// Top level of the Izhikevich neuron step block.
//
//  channel  direction  handshake                 payload
//  in       in         i_in_valid / o_in_stall   i_input_current
//  out      out        o_out_valid / i_out_stall o_fired, o_membrane_potential,
//                                                o_recovery_value, o_window_spikes
//  cfg      in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each item runs 2^s Euler substeps, s = min(dt_shift, 8); each substep does
// v*v and b*v, then 0.04*sq and a*(bv-u), then the update.
// One item is in work at a time; the next beat is taken once the result
// has moved into the output register.
// A stalled output beat holds; a finished item waits for the register to free.
// Synchronous active-low reset restores the rest state and default registers.
`include "izhikevich_neuron_step_defines.svh"

module izhikevich_neuron_step import izh_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [31:0]    i_input_current,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_fired,
    output logic signed [31:0]    o_membrane_potential,
    output logic signed [31:0]    o_recovery_value,
    output logic [CNT_W-1:0]      o_window_spikes
);

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    izh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    izh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    izh_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_cfg                (w_cfg),
        .i_input_current      (i_input_current),
        .o_fired              (o_fired),
        .o_membrane_potential (o_membrane_potential),
        .o_recovery_value     (o_recovery_value),
        .o_window_spikes      (o_window_spikes)
    );

    `IZH_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `IZH_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall,
                "beat taken while busy")
    `IZH_ASSERT(a_commit_shows, w_cmd.commit |=> o_out_valid, "committed result not presented")
    `IZH_ASSERT(a_floor_held,
                (o_out_valid && !o_fired) |-> (o_membrane_potential >= FLOOR_POT),
                "potential below floor without spike")
    // the result register holds no value until the first commit
    `IZH_ASSERT(a_window_bound,
                o_out_valid |-> (o_window_spikes <= CNT_W'(WINDOW)),
                "window count exceeds window")

endmodule

// ===== verif/izhikevich_neuron_step_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Izhikevich neuron step block.
module izhikevich_neuron_step_test;
    import izh_pkg::*;

    // long enough for two items at the longest substep count
    localparam int LONG_HOLD    = 2000;
    localparam int RANDOM_ITEMS = 1330;
    localparam int Q_ONE        = 65536;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam logic signed [63:0] SQ_COEF = 64'sd2621;
    localparam logic signed [63:0] Q32_MAX = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] Q32_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic               fired;
        logic signed [31:0] potential;
        logic signed [31:0] recovery;
        logic [CNT_W-1:0]   spikes;
    } t_neuron_out;

    typedef enum logic [1:0] {
        GAPS_TX_LIGHT,  // sender 7 %, receiver 60 %
        GAPS_RX_LIGHT,  // sender 60 %, receiver 7 %
        GAPS_NONE
    } t_gap_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [31:0]       i_input_current = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_fired;
    logic signed [31:0]       o_membrane_potential;
    logic signed [31:0]       o_recovery_value;
    logic [CNT_W-1:0]         o_window_spikes;

    // predictor copy of the registers and of the neuron state
    logic [16:0]              cfg_a = 17'd1311;
    logic [16:0]              cfg_b = 17'd13107;
    logic signed [23:0]       cfg_c = -24'sd4259840;
    logic [20:0]              cfg_d = 21'd524288;
    logic [26:0]              cfg_gain = 27'd65536;
    logic [3:0]               cfg_dt = 4'd1;
    logic signed [31:0]       pot_state = REST_POT;
    logic signed [31:0]       rec_state = '0;
    logic [63:0]              spike_hist = '0;
    logic [CNT_W-1:0]         spike_total = '0;

    logic signed [31:0]       pending_currents[$];
    t_neuron_out              expected_steps[$];
    t_gap_mode                gap_mode = GAPS_TX_LIGHT;
    int unsigned              mismatches = 0;
    int unsigned              hold_requests = 0;
    int unsigned              hold_seen = 0;
    int unsigned              hold_left = 0;

    izhikevich_neuron_step dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_input_current      (i_input_current),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_fired              (o_fired),
        .o_membrane_potential (o_membrane_potential),
        .o_recovery_value     (o_recovery_value),
        .o_window_spikes      (o_window_spikes)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [63:0] clamp_q32(input logic signed [63:0] x);
        if (x > Q32_MAX) return Q32_MAX;
        if (x < Q32_MIN) return Q32_MIN;
        return x;
    endfunction

    // One time step of the neuron: Euler substeps, spike or floor, window count.
    function automatic void advance_neuron(input logic signed [31:0] current);
        logic signed [63:0] cur, gain, a, b, drive, v, u, sq, dv, bv, du, nv;
        int unsigned        shift, k;
        logic               spike, leaving;
        t_neuron_out        res;
        cur   = {{32{current[31]}}, current};
        gain  = {37'd0, cfg_gain};
        a     = {47'd0, cfg_a};
        b     = {47'd0, cfg_b};
        shift = (cfg_dt > MAX_SHIFT) ? MAX_SHIFT : cfg_dt;
        drive = (gain * cur) >>> 16;
        v     = {{32{pot_state[31]}}, pot_state};
        u     = {{32{rec_state[31]}}, rec_state};
        for (k = 0; k < (32'd1 << shift); k++) begin
            sq = (v * v) >>> 16;
            dv = ((sq * SQ_COEF) >>> 16) + 64'sd5 * v + BIAS_TERM - u + drive;
            bv = (b * v) >>> 16;
            du = (a * (bv - u)) >>> 16;
            nv = clamp_q32(v + (dv >>> shift));
            u  = clamp_q32(u + (du >>> shift));
            v  = nv;
        end
        spike = (v > PEAK_POT);
        if (spike) begin
            v = {{40{cfg_c[23]}}, cfg_c};
            u = clamp_q32(u + $signed({43'd0, cfg_d}));
        end else if (v < FLOOR_POT) begin
            v = REST_POT;
        end
        pot_state   = v[31:0];
        rec_state   = u[31:0];
        leaving     = spike_hist[63];
        spike_hist  = {spike_hist[62:0], spike};
        spike_total = spike_total + CNT_W'(spike) - CNT_W'(leaving);
        res.fired     = spike;
        res.potential = pot_state;
        res.recovery  = rec_state;
        res.spikes    = spike_total;
        expected_steps.push_back(res);
    endfunction

    function automatic bit tx_gap();
        case (gap_mode)
            GAPS_TX_LIGHT: return $urandom_range(0, 99) < 7;
            GAPS_RX_LIGHT: return $urandom_range(0, 99) < 60;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit rx_gap();
        case (gap_mode)
            GAPS_TX_LIGHT: return $urandom_range(0, 99) < 60;
            GAPS_RX_LIGHT: return $urandom_range(0, 99) < 7;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Input beats: the predictor runs on every accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_neuron(i_input_current);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_currents.size() != 0 && !tx_gap()) begin
                    i_input_current <= pending_currents.pop_front();
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result beats and receiver back-pressure.
    always @(posedge i_clk) begin
        t_neuron_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_steps.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, got %b %0h %0h %0d",
                             $time, o_fired, o_membrane_potential, o_recovery_value,
                             o_window_spikes);
                    mismatches++;
                end else begin
                    want = expected_steps.pop_front();
                    compare_field("fired", 32'(want.fired), 32'(o_fired));
                    compare_field("membrane_potential", want.potential, o_membrane_potential);
                    compare_field("recovery_value", want.recovery, o_recovery_value);
                    compare_field("window_spikes", 32'(want.spikes), 32'(o_window_spikes));
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= rx_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_RECOVERY_RATE:        cfg_a = data[16:0];
            CFG_RECOVERY_SENSITIVITY: cfg_b = data[16:0];
            CFG_RESET_POTENTIAL:      cfg_c = data[23:0];
            CFG_RECOVERY_JUMP:        cfg_d = data[20:0];
            CFG_CURRENT_GAIN:         cfg_gain = data[26:0];
            CFG_DT_SHIFT:             cfg_dt = data[3:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] a, b, c, d, gain, dt,
                               input bit stray);
        write_reg(CFG_RECOVERY_RATE, a);
        write_reg(CFG_RECOVERY_SENSITIVITY, b);
        write_reg(CFG_RESET_POTENTIAL, c);
        write_reg(CFG_RECOVERY_JUMP, d);
        write_reg(CFG_CURRENT_GAIN, gain);
        write_reg(CFG_DT_SHIFT, dt);
        if (stray) begin
            write_reg(CFG_UNUSED_LO, CFG_DATA_W'($urandom));
            write_reg(CFG_UNUSED_HI, CFG_DATA_W'($urandom));
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sampled at the falling edge so that every rising-edge update has settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_currents.size() != 0 || i_in_valid || expected_steps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Extremes, the register's full width now and then, and junk above it.
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input longint lo, input longint hi,
                                                       input int w);
        longint      val;
        logic [63:0] mask;
        logic [63:0] raw;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        mask = (64'd1 << w) - 64'd1;
        if (pick < 3) val = lo;
        else if (pick < 6) val = hi;
        else if (pick == 6) val = longint'($urandom);
        else val = lo + longint'($urandom_range(0, 32'(hi - lo)));
        raw = val;
        raw = raw & mask;
        if ($urandom_range(0, 3) == 0) raw = raw | ({32'd0, $urandom} & ~mask);
        return raw[CFG_DATA_W-1:0];
    endfunction

    task automatic random_config(output int unsigned dt_val);
        logic [CFG_DATA_W-1:0] gain;
        int unsigned           pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) dt_val = $urandom_range(0, 2);
        else if (pick < 17) dt_val = $urandom_range(3, 5);
        else if (pick < 19) dt_val = $urandom_range(6, 8);
        else dt_val = $urandom_range(9, 15);
        // half the time a gain near unity keeps the neuron out of saturation
        if ($urandom_range(0, 1) != 0)
            gain = CFG_DATA_W'($urandom_range(Q_ONE / 2, 2 * Q_ONE));
        else gain = pick_reg(0, 67108864, 27);
        load_config(pick_reg(0, 65536, 17), pick_reg(0, 65536, 17),
                    pick_reg(-6553600, 0, 24), pick_reg(0, 1310720, 21),
                    gain, CFG_DATA_W'(dt_val), $urandom_range(0, 3) == 0);
    endtask

    function automatic logic signed [31:0] random_current();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return $urandom;
        if (pick == 2) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (pick < 6) return -$signed($urandom_range(0, 30 * Q_ONE));
        return $signed($urandom_range(0, 40 * Q_ONE));
    endfunction

    initial begin
        int unsigned n_items, dt_now, done_items, phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at their reset values: rest, drive to spike, saturate both ways
        pending_currents.push_back(32'sd0);
        pending_currents.push_back(32'sd1);
        pending_currents.push_back(-32'sd1);
        repeat (4) pending_currents.push_back(32'(10 * Q_ONE));
        pending_currents.push_back(32'sh7FFF_FFFF);
        pending_currents.push_back(32'sh8000_0000);
        repeat (3) pending_currents.push_back(32'(20 * Q_ONE));
        pending_currents.push_back(32'(-30 * Q_ONE));
        pending_currents.push_back(32'(5 * Q_ONE));
        wait_drained();

        // every register at its low end
        load_config(0, 0, CFG_DATA_W'(-6553600), 0, 0, 0, 1'b0);
        pending_currents.push_back(32'sh7FFF_FFFF);
        pending_currents.push_back(32'(10 * Q_ONE));
        wait_drained();

        // every register at its high end, longest substep count
        load_config(65536, 65536, 0, 1310720, 67108864, 8, 1'b0);
        pending_currents.push_back(32'(10 * Q_ONE));
        pending_currents.push_back(-32'sd1);
        pending_currents.push_back(32'sh8000_0000);
        wait_drained();

        // full register width, shift beyond the cap
        load_config(27'h1FFFF, 27'h1FFFF, 27'h7FFFFF, 27'h1FFFFF, 27'h7FFFFFF, 15, 1'b0);
        pending_currents.push_back(32'(3 * Q_ONE));
        pending_currents.push_back(-32'(3 * Q_ONE));
        wait_drained();

        // writes to unused indexes must leave the registers alone
        load_config(1311, 13107, CFG_DATA_W'(-4259840), 524288, 65536, 9, 1'b1);
        pending_currents.push_back(32'(15 * Q_ONE));
        pending_currents.push_back(32'(15 * Q_ONE));
        wait_drained();

        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items < RANDOM_ITEMS / 3) gap_mode = GAPS_TX_LIGHT;
            else if (done_items < 2 * RANDOM_ITEMS / 3) gap_mode = GAPS_RX_LIGHT;
            else gap_mode = GAPS_NONE;
            random_config(dt_now);
            n_items = (dt_now >= 6) ? 6 : $urandom_range(60, 140);
            repeat (n_items) pending_currents.push_back(random_current());
            if (phase == 2) begin
                // long receiver hold while the sender keeps offering beats
                @(negedge i_clk);
                hold_requests++;
            end
            done_items += n_items;
            phase++;
            wait_drained();
        end

        repeat (800) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/izh_pkg.sv
src/izh_cfg_regs.sv
src/izh_ctrl.sv
src/izh_datapath.sv
src/izhikevich_neuron_step.sv
verif/izhikevich_neuron_step_test.sv
